// ----- rtl/sopdj_pkg.sv -----
// ----------------------------------------------------------------------------
// sopdj_pkg: shared types and constants of the stereo one-pole DJ filter
// Sample formats, filter mode codes, register indexes and channel controls.
// ----------------------------------------------------------------------------
package sopdj_pkg;

    localparam int InW   = 20;
    localparam int OutW  = 16;
    localparam int CoefW = 16;
    localparam int GainW = CoefW + 1;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = CoefW;

    localparam logic [GainW-1:0] GainOne = GainW'(1) << CoefW;

    localparam logic [CfgAddrW-1:0] CFG_FILTER_MODE = 1'd0;
    localparam logic [CfgAddrW-1:0] CFG_POLE_COEF   = 1'd1;

    typedef logic signed [InW-1:0]  t_sample;
    typedef logic signed [OutW-1:0] t_pcm;

    typedef enum logic [1:0] {
        MODE_BYPASS   = 2'd0,
        MODE_LOWPASS  = 2'd1,
        MODE_HIGHPASS = 2'd2
    } t_mode;

    typedef struct packed {
        logic             step;
        t_mode            mode;
        logic [GainW-1:0] gain;
    } t_chan_ctl;

endpackage

// ----- rtl/sopdj_if.sv -----
// ----------------------------------------------------------------------------
// sopdj_if: stream channels of the stereo one-pole DJ filter
// Input frame channel and result frame channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sopdj_in_if import sopdj_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample mix_left;
    t_sample mix_right;

    modport source (output valid, output mix_left, output mix_right, input ready);
    modport sink   (input valid, input mix_left, input mix_right, output ready);
endinterface

interface sopdj_out_if import sopdj_pkg::*; ();
    logic valid;
    logic ready;
    t_pcm out_left;
    t_pcm out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ----- rtl/sopdj_chan.sv -----
// ----------------------------------------------------------------------------
// sopdj_chan: one channel of the filter
// Low-pass state update, mode select, Q0.15 saturation and result register.
// ----------------------------------------------------------------------------
module sopdj_chan import sopdj_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_chan_ctl i_ctl,
    input  t_sample   i_x,
    output t_pcm      o_y
);

    t_sample                r_state;
    t_sample                n_state;
    t_pcm                   r_y;
    t_pcm                   n_y;

    logic signed [InW:0]         diff;
    logic signed [InW+GainW:0]   prod;
    logic signed [InW+GainW:0]   rnd;
    logic signed [InW+2:0]       delta;
    logic signed [InW+2:0]       s_wide;
    logic signed [InW:0]         sel;
    logic signed [InW-1:0]       half;
    logic                        filt;

    // s' = s + round(b * (x - s) / 2^16), same as (b*x + a*s) / 2^16
    always_comb begin
        diff   = {i_x[InW-1], i_x} - {r_state[InW-1], r_state};
        prod   = $signed({1'b0, i_ctl.gain}) * diff;
        rnd    = prod + (InW+GainW+1)'(32768);
        delta  = (InW+3)'($signed(rnd[InW+GainW:CoefW]));
        s_wide = delta + (InW+3)'(r_state);
        filt   = (i_ctl.mode == MODE_LOWPASS) || (i_ctl.mode == MODE_HIGHPASS);
        n_state = filt ? s_wide[InW-1:0] : r_state;

        case (i_ctl.mode)
            MODE_LOWPASS:  sel = (InW+1)'(n_state);
            MODE_HIGHPASS: sel = {i_x[InW-1], i_x} - {n_state[InW-1], n_state};
            default:       sel = (InW+1)'(i_x);
        endcase

        half = sel[InW:1];
        if (half[InW-1:OutW-1] == '0 || half[InW-1:OutW-1] == '1) begin
            n_y = half[OutW-1:0];
        end else if (half[InW-1]) begin
            n_y = {1'b1, {(OutW-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(OutW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_ctl.step) begin
            r_state <= n_state;
        end
        if (i_ctl.step) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

    a_bypass_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !filt) |=> $stable(r_state))
        else $error("state moved in bypass");

    a_zero_coef_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && filt && i_ctl.gain == GainOne) |=> (r_state == $past(i_x)))
        else $error("state does not follow input with zero coefficient");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.step |=> $stable(r_state))
        else $error("state moved without a step");

endmodule

// ----- rtl/stereo_one_pole_dj_filter.sv -----
// ----------------------------------------------------------------------------
// stereo_one_pole_dj_filter: stereo one-pole low-pass / high-pass filter
//
//   port      dir  beat
//   i_mix     in   mix_left, mix_right   signed Q3.16 frame
//   o_flt     out  out_left, out_right   signed Q0.15 frame, saturated
//   i_cfg_*   in   index 0 filter_mode, index 1 pole_coef
//
// One frame per cycle sustained while o_flt is ready; a taken beat passes the
// input register, then the state update into the result register, to o_flt.
// The state feedback is one combinational multiply-add per channel.
// Synchronous active-low reset clears both states, mode (bypass) and coef.
// A stalled output holds its beat; the input register still takes one more.
// ----------------------------------------------------------------------------
module stereo_one_pole_dj_filter import sopdj_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    sopdj_in_if.sink            i_mix,
    sopdj_out_if.source         o_flt
);

    t_mode            r_mode;
    logic [GainW-1:0] r_gain;
    logic             r_in_vld;
    logic             r_out_vld;
    t_sample          r_x_left;
    t_sample          r_x_right;

    logic             advance;
    logic             accept;
    t_chan_ctl        ctl;

    assign advance     = !r_out_vld || o_flt.ready;
    assign i_mix.ready = !r_in_vld || advance;
    assign accept      = i_mix.valid && i_mix.ready;

    assign ctl = '{step: r_in_vld && advance, mode: r_mode, gain: r_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BYPASS;
            r_gain    <= GainOne;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_FILTER_MODE: r_mode <= t_mode'(i_cfg_wdata[1:0]);
                    CFG_POLE_COEF:   r_gain <= GainOne - GainW'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
        if (accept) begin
            r_x_left  <= i_mix.mix_left;
            r_x_right <= i_mix.mix_right;
        end
    end

    sopdj_chan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_x     (r_x_left),
        .o_y     (o_flt.out_left)
    );

    sopdj_chan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_x     (r_x_right),
        .o_y     (o_flt.out_right)
    );

    assign o_flt.valid = r_out_vld;

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.step |=> r_out_vld)
        else $error("result register not loaded after step");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |-> !i_mix.ready)
        else $error("input taken while both stages are full");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_vld && !i_mix.valid && advance) |=> !r_out_vld)
        else $error("result appeared without a beat");

endmodule

// ----- verif/stereo_one_pole_dj_filter_tb.sv -----
// ----------------------------------------------------------------------------
// stereo_one_pole_dj_filter_tb: self-checking regression of the stereo DJ filter
// Streams stereo frames through bypass, low-pass, high-pass and the unused mode
// code, across coefficient extremes and random settings. A bit-accurate model
// of the one-pole state predicts each output frame, and a scoreboard compares
// them in order. Both stream sides idle in random bursts, and the output side
// holds off for a long stretch once so that the input backs up.
// ----------------------------------------------------------------------------
module stereo_one_pole_dj_filter_tb;
    import sopdj_pkg::*;

    localparam logic [1:0] ModeUnused = 2'd3;
    localparam int StateW = 24;
    localparam int StallLimit = 4000;
    localparam int HoldOffCycles = 90;
    localparam int PhaseFrames = 60;
    localparam int RandPhases = 12;

    class dj_filter_scoreboard;
        typedef struct {
            t_pcm left;
            t_pcm right;
        } t_pcm_frame;

        t_pcm_frame expected_frames[$];
        logic [1:0] mode;
        logic [CoefW-1:0] coef;
        logic signed [StateW-1:0] lp_left;
        logic signed [StateW-1:0] lp_right;
        int errors;

        function new();
            mode = MODE_BYPASS;
            coef = '0;
            lp_left = '0;
            lp_right = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
            if (idx == CFG_FILTER_MODE) begin
                mode = data[1:0];
            end else if (idx == CFG_POLE_COEF) begin
                coef = data;
            end
        endfunction

        function t_pcm saturate_q15(longint q16);
            longint v;
            v = q16 >>> 1;
            if (v > 32767) begin
                v = 32767;
            end
            if (v < -32768) begin
                v = -32768;
            end
            return t_pcm'(v);
        endfunction

        function t_pcm filter_channel(t_sample x, inout logic signed [StateW-1:0] st);
            longint xs;
            longint ss;
            longint a;
            longint b;
            longint acc;
            longint y;
            xs = x;
            ss = st;
            if (mode != MODE_LOWPASS && mode != MODE_HIGHPASS) begin
                return saturate_q15(xs);
            end
            a = coef;
            b = 65536 - a;
            acc = b * xs + a * ss;
            ss = (acc + 32768) >>> 16;
            st = ss[StateW-1:0];
            y = (mode == MODE_LOWPASS) ? ss : xs - ss;
            return saturate_q15(y);
        endfunction

        function void note_frame(t_sample left, t_sample right);
            t_pcm_frame f;
            f.left = filter_channel(left, lp_left);
            f.right = filter_channel(right, lp_right);
            expected_frames.insert(expected_frames.size(), f);
        endfunction

        function void check_frame(t_pcm left, t_pcm right);
            t_pcm_frame f;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected output beat left %0d right %0d",
                         $time, left, right);
                errors++;
                return;
            end
            f = expected_frames.pop_front();
            if (left !== f.left) begin
                $display("%0t: out_left expected %0d actual %0d", $time, f.left, left);
                errors++;
            end
            if (right !== f.right) begin
                $display("%0t: out_right expected %0d actual %0d", $time, f.right, right);
                errors++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_wdata;

    sopdj_in_if mix_if ();
    sopdj_out_if flt_if ();

    dj_filter_scoreboard sb;

    bit src_idle;
    bit sink_idle;
    int hold_req;

    stereo_one_pole_dj_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mix       (mix_if),
        .o_flt       (flt_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        sb = new();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (mix_if.valid && mix_if.ready) begin
                sb.note_frame(mix_if.mix_left, mix_if.mix_right);
            end
            if (flt_if.valid && flt_if.ready) begin
                sb.check_frame(flt_if.out_left, flt_if.out_right);
            end
        end
    end

    initial begin : flt_sink
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        flt_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                flt_if.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                flt_if.ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 14) - 1;
                flt_if.ready <= 1'b0;
            end else begin
                flt_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge i_clk);
            if ((mix_if.valid && mix_if.ready) || (flt_if.valid && flt_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
        $display("stereo_one_pole_dj_filter regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [CfgAddrW-1:0] idx,
                             input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] m);
        write_reg(CFG_FILTER_MODE, {14'($urandom), m});
    endtask

    task automatic send_frame(input t_sample left, input t_sample right);
        int gap;
        @(negedge i_clk);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            mix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        mix_if.valid <= 1'b1;
        mix_if.mix_left <= left;
        mix_if.mix_right <= right;
        do begin
            @(posedge i_clk);
        end while (!mix_if.ready);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        mix_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample(t_sample prev);
        int off;
        off = $urandom_range(0, 200);
        case ($urandom_range(0, 5))
            0: return t_sample'($urandom);
            1: return $urandom_range(0, 1) ? t_sample'(524287) : t_sample'(-524288);
            2: return t_sample'(int'($urandom_range(0, 8000)) - 4000);
            3: return $urandom_range(0, 1) ? t_sample'(65436 + off) : t_sample'(-65636 + off);
            default: return prev;
        endcase
    endfunction

    function automatic logic [CoefW-1:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CoefW'($urandom_range(60000, 65535));
            default: return CoefW'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [1:0] mode_pick[6];
        t_sample prev_left;
        t_sample prev_right;
        mode_pick = '{MODE_LOWPASS, MODE_HIGHPASS, MODE_LOWPASS,
                      MODE_HIGHPASS, MODE_BYPASS, ModeUnused};
        prev_left = '0;
        prev_right = '0;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        mix_if.valid = 1'b0;
        mix_if.mix_left = '0;
        mix_if.mix_right = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bypass out of reset: full range and clip edges
        send_frame(524287, -524288);
        send_frame(-524288, 524287);
        send_frame(0, -1);
        send_frame(65535, -65536);
        send_frame(65534, -65538);
        send_frame(1, -2);
        end_stream();
        wait_drained();

        // zero coefficient: state tracks input
        set_mode(MODE_LOWPASS);
        write_reg(CFG_POLE_COEF, '0);
        send_frame(524287, -524288);
        send_frame(-524288, 524287);
        send_frame(12345, -777);
        end_stream();
        wait_drained();

        write_reg(CFG_POLE_COEF, '1);
        send_frame(524287, -524288);
        send_frame(524287, -524288);
        send_frame(524287, -524288);
        end_stream();
        wait_drained();

        set_mode(MODE_HIGHPASS);
        send_frame(524287, -524288);
        send_frame(-524288, 524287);
        send_frame(0, 0);
        end_stream();
        wait_drained();

        // unused mode code passes through and keeps state
        write_reg(CFG_FILTER_MODE, '1);
        send_frame(100000, -100000);
        send_frame(1, 1);
        end_stream();
        wait_drained();

        set_mode(MODE_HIGHPASS);
        write_reg(CFG_POLE_COEF, 16'h8000);
        send_frame(-300000, 300000);
        send_frame(0, 0);
        end_stream();
        wait_drained();

        for (int ph = 0; ph < RandPhases; ph++) begin
            set_mode(mode_pick[$urandom_range(0, 5)]);
            write_reg(CFG_POLE_COEF, rand_coef());
            if (ph == RandPhases - 1) begin
                src_idle = 1'b0;
                sink_idle = 1'b0;
            end else begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            if (ph == 3) begin
                hold_req = HoldOffCycles;
            end
            for (int n = 0; n < PhaseFrames; n++) begin
                prev_left = rand_sample(prev_left);
                prev_right = rand_sample(prev_right);
                send_frame(prev_left, prev_right);
            end
            end_stream();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected frames never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("stereo_one_pole_dj_filter regression: pass");
        end else begin
            $display("stereo_one_pole_dj_filter regression: fail");
        end
        $finish;
    end
endmodule
